// File: rtl/core/rpa_pkg.sv
// ---------------------------------------------------------------------------
// rpa_pkg
// Shared constants, types and the arctangent table of the point rotator.
// ---------------------------------------------------------------------------
package rpa_pkg;

   // default number of cordic micro-rotations
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;
   localparam int ATAN_IDX_W        = 5;

   // angle datapath widths
   localparam int ZW = 35;
   localparam int XW = 34;

   localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
   localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

   // geometry carried alongside the angle path
   typedef struct packed {
      logic [2:0][32:0] d;
      logic [2:0][31:0] ctr;
      logic [2:0][15:0] a;
   } geo_type;

   // truncated Q30 arctangent of 2^-i
   function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/rotate_point_about_axis_core.sv
// ---------------------------------------------------------------------------
// rotate_point_about_axis_core
// Pipelined axis-angle rotation of a point about a center, cordic sin/cos.
// ---------------------------------------------------------------------------
//  channel | direction | ports                        | handshake
//  req     | in        | req_point_*, req_center_*,   | req_valid / req_ready
//          |           | req_axis_*, req_angle        |
//  rsp     | out       | rsp_rotated_*                | rsp_valid / rsp_ready
//
// one item per cycle while req_ready is high; pipeline: fold stage, one
// cordic stage per micro-rotation, three matrix stages, one product stage,
// output register. synchronous reset clears valid bits only. a two-entry
// output (register plus skid) lets the pipeline advance while the output
// waits; req_ready drops only when both entries hold items.
// ---------------------------------------------------------------------------
module rotate_point_about_axis_core #(
   parameter int CORDIC_STAGES = rpa_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [15:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rotated_x,
   output logic signed [31:0] rsp_rotated_y,
   output logic signed [31:0] rsp_rotated_z
);
   import rpa_pkg::*;

   localparam int N = CORDIC_STAGES;

   logic ena;

   // cordic stages, index 0 is the folded input
   logic signed [XW-1:0] x_ff [0:N];
   logic signed [XW-1:0] x_in [0:N];
   logic signed [XW-1:0] y_ff [0:N];
   logic signed [XW-1:0] y_in [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   logic signed [ZW-1:0] z_in [0:N];
   logic                 n_ff [0:N];
   logic                 n_in [0:N];
   geo_type              g_ff [0:N];
   geo_type              g_in [0:N];
   logic [N:0]           v_ff;
   logic [N:0]           v_in;

   always_comb begin
      logic signed [ZW-1:0] zf;
      logic                 nf;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] at;
      // input fold into the principal range
      zf = {req_angle[15], req_angle, 18'b0};
      nf = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (zf > Q30_HALF_PI) begin
            zf = zf - Q30_PI;
            nf = ~nf;
         end else if (zf < -Q30_HALF_PI) begin
            zf = zf + Q30_PI;
            nf = ~nf;
         end
      end
      x_in[0] = CORDIC_GAIN;
      y_in[0] = '0;
      z_in[0] = zf;
      n_in[0] = nf;
      v_in[0] = req_valid;
      g_in[0].d[0] = 33'(req_point_x) - 33'(req_center_x);
      g_in[0].d[1] = 33'(req_point_y) - 33'(req_center_y);
      g_in[0].d[2] = 33'(req_point_z) - 33'(req_center_z);
      g_in[0].ctr  = {req_center_z, req_center_y, req_center_x};
      g_in[0].a    = {req_axis_z, req_axis_y, req_axis_x};
      // one micro-rotation per stage
      for (int k = 1; k <= N; k++) begin
         dx = y_ff[k-1] >>> (k-1);
         dy = x_ff[k-1] >>> (k-1);
         at = $signed({3'b000, atan_q30(ATAN_IDX_W'(k-1))});
         if (!z_ff[k-1][ZW-1]) begin
            x_in[k] = x_ff[k-1] - dx;
            y_in[k] = y_ff[k-1] + dy;
            z_in[k] = z_ff[k-1] - at;
         end else begin
            x_in[k] = x_ff[k-1] + dx;
            y_in[k] = y_ff[k-1] - dy;
            z_in[k] = z_ff[k-1] + at;
         end
         n_in[k] = n_ff[k-1];
         g_in[k] = g_ff[k-1];
         v_in[k] = v_ff[k-1];
      end
   end

   // cordic registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ena) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         for (int k = 0; k <= N; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            n_ff[k] <= n_in[k];
            g_ff[k] <= g_in[k];
         end
      end
   end

   // m1: sign fix, one minus cosine, axis products
   logic signed [XW-1:0]  c_ff, s_ff;
   logic signed [XW:0]    t_ff;
   logic signed [31:0]    aa_ff [3][3];
   geo_type               g1_ff;
   logic                  v1_ff;

   always_ff @(posedge clock) begin
      logic signed [XW-1:0] cv;
      if (ena) begin
         cv     = n_ff[N] ? -x_ff[N] : x_ff[N];
         c_ff  <= cv;
         s_ff  <= n_ff[N] ? -y_ff[N] : y_ff[N];
         t_ff  <= 35'sd1073741824 - 35'(cv);
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               aa_ff[r][k] <= $signed(g_ff[N].a[r]) * $signed(g_ff[N].a[k]);
            end
         end
         g1_ff <= g_ff[N];
      end
   end

   // m2: products with cosine, one minus cosine and sine
   logic signed [66:0] pm_ff [3][3];
   logic signed [49:0] sk_ff [3];
   logic signed [31:0] ad_ff [3];
   geo_type            g2_ff;
   logic               v2_ff;

   always_ff @(posedge clock) begin
      logic signed [32:0] om;
      if (ena) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               if (r == k) begin
                  om = 33'sd268435456 - 33'(aa_ff[r][r]);
                  pm_ff[r][k] <= 67'(om) * 67'(c_ff);
               end else begin
                  pm_ff[r][k] <= 67'(aa_ff[r][k]) * 67'(t_ff);
               end
            end
            sk_ff[r] <= 50'($signed(g1_ff.a[r])) * 50'(s_ff);
            ad_ff[r] <= aa_ff[r][r];
         end
         g2_ff <= g1_ff;
      end
   end

   // m3: rounding, skew terms, entry saturation
   logic signed [31:0] m_ff [3][3];
   geo_type            g3_ff;
   logic               v3_ff;

   always_ff @(posedge clock) begin
      logic signed [67:0] e;
      logic signed [67:0] sk;
      int                 j;
      if (ena) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               j = 3 - r - k;
               if (r == k) begin
                  e = (68'(ad_ff[r]) <<< 2) + ((68'(pm_ff[r][k]) + 68'sd134217728) >>> 28);
               end else begin
                  sk = (68'(sk_ff[j]) + 68'sd8192) >>> 14;
                  e  = (68'(pm_ff[r][k]) + 68'sd134217728) >>> 28;
                  if ((k - r + 3) % 3 == 1) e = e - sk;
                  else                      e = e + sk;
               end
               if (e > 68'sd2147483647)       m_ff[r][k] <= 32'sh7FFFFFFF;
               else if (e < -68'sd2147483648) m_ff[r][k] <= 32'sh80000000;
               else                           m_ff[r][k] <= e[31:0];
            end
         end
         g3_ff <= g2_ff;
      end
   end

   // p1: matrix times difference
   logic signed [64:0] pr_ff [3][3];
   logic [2:0][31:0]   ctr4_ff;
   logic               v4_ff;

   always_ff @(posedge clock) begin
      if (ena) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               pr_ff[r][k] <= 65'(m_ff[r][k]) * 65'($signed(g3_ff.d[k]));
            end
         end
         ctr4_ff <= g3_ff.ctr;
      end
   end

   // matrix stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (ena) begin
         v1_ff <= v_ff[N];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // accumulate with the center and saturate
   logic [2:0][31:0] res_in;

   always_comb begin
      logic signed [39:0] acc;
      for (int r = 0; r < 3; r++) begin
         acc = 40'($signed(ctr4_ff[r]));
         for (int k = 0; k < 3; k++) begin
            acc = acc + 40'((pr_ff[r][k] + 65'sd536870912) >>> 30);
         end
         if (acc > 40'sd2147483647)       res_in[r] = 32'h7FFFFFFF;
         else if (acc < -40'sd2147483648) res_in[r] = 32'h80000000;
         else                             res_in[r] = acc[31:0];
      end
   end

   // output register and skid entry
   logic [2:0][31:0] o_ff, sk_o_ff;
   logic             ov_ff, skv_ff;

   assign ena = ~skv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff  <= 1'b0;
         skv_ff <= 1'b0;
      end else if (skv_ff) begin
         if (rsp_ready) skv_ff <= 1'b0;
      end else if (ov_ff && !rsp_ready) begin
         if (v4_ff) skv_ff <= 1'b1;
      end else begin
         ov_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skv_ff) begin
         if (rsp_ready) o_ff <= sk_o_ff;
      end else if (ov_ff && !rsp_ready) begin
         sk_o_ff <= res_in;
      end else begin
         o_ff <= res_in;
      end
   end

   assign req_ready     = ena;
   assign rsp_valid     = ov_ff;
   assign rsp_rotated_x = o_ff[0];
   assign rsp_rotated_y = o_ff[1];
   assign rsp_rotated_z = o_ff[2];

endmodule

// File: rtl/core/rpa_checker.sv
// ---------------------------------------------------------------------------
// rpa_checker
// Port-level checks of the point rotator, bound to the top level.
// ---------------------------------------------------------------------------
module rpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_rotated_x
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rotated_x))
      else $error("result changed while stalled");

   // input back-pressure only with a result waiting
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // reset empties the block
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // handshake signals always known out of reset
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_ready, rsp_valid, rsp_ready}))
      else $error("unknown handshake signal");

endmodule

bind rotate_point_about_axis_core rpa_checker u_rpa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_rotated_x (rsp_rotated_x)
);
